### sv/jse_pkg.sv
// jse_pkg: shared types, constants and helpers for the JSON string escaper.
// Used by jse_esc_unit, json_string_escaper_utf8_truncate and its testbench.
// No dependencies.
package jse_pkg;

    localparam int HOLD_DEPTH_DEF = 4;
    localparam int INDEX_BITS_DEF = 11;

    localparam int MAX_BYTES_W = 10;
    localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RST = 10'd300;

    localparam int ESC_STEP_W = 3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [7:0] UTF8_CONT_MASK = 8'hC0;
    localparam logic [7:0] UTF8_CONT_VAL  = 8'h80;

    typedef struct packed {
        logic       mode;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } out_item_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10)
        begin
            d = CH_ZERO + {4'd0, nib};
        end
        else
        begin
            d = 8'h61 + {4'd0, nib} - 8'd10;
        end
        return d;
    endfunction

endpackage

### sv/jse_esc_unit.sv
// jse_esc_unit: produces one character of the escaped form of a byte per step.
// Depends on jse_pkg.
module jse_esc_unit (
    input  logic [7:0]                     c,
    input  logic [jse_pkg::ESC_STEP_W-1:0] step,
    output logic [7:0]                     ch,
    output logic                           last
);

    always_comb
    begin
        ch   = c;
        last = 1'b1;
        case (c)
            jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH:
            begin
                ch   = (step == '0) ? jse_pkg::CH_BSLASH : c;
                last = (step != '0);
            end
            jse_pkg::CH_LF:
            begin
                ch   = (step == '0) ? jse_pkg::CH_BSLASH : jse_pkg::CH_N;
                last = (step != '0);
            end
            jse_pkg::CH_CR:
            begin
                ch   = (step == '0) ? jse_pkg::CH_BSLASH : jse_pkg::CH_R;
                last = (step != '0);
            end
            jse_pkg::CH_TAB:
            begin
                ch   = (step == '0) ? jse_pkg::CH_BSLASH : jse_pkg::CH_T;
                last = (step != '0);
            end
            default:
            begin
                if (c < jse_pkg::CTRL_LIMIT)
                begin
                    // \u00xx, six characters
                    last = 1'b0;
                    case (step)
                        3'd0:    ch = jse_pkg::CH_BSLASH;
                        3'd1:    ch = jse_pkg::CH_U;
                        3'd2:    ch = jse_pkg::CH_ZERO;
                        3'd3:    ch = jse_pkg::CH_ZERO;
                        3'd4:    ch = jse_pkg::hex_digit(c[7:4]);
                        default:
                        begin
                            ch   = jse_pkg::hex_digit(c[3:0]);
                            last = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

### sv/jse_hold_buf.sv
// jse_hold_buf: small buffer of held-back bytes of an unfinished UTF-8 sequence.
// Depends on jse_pkg only through the top level's parameters.
module jse_hold_buf #(
    parameter int HOLD_DEPTH = 4,
    parameter int HOLD_BITS  = 2
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [HOLD_BITS-1:0] wr_idx,
    input  logic [7:0]           wr_data,
    input  logic [HOLD_BITS-1:0] rd_idx,
    output logic [7:0]           rd_data
);

    logic [7:0] held_reg [HOLD_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            held_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = held_reg[rd_idx];

endmodule

### sv/json_string_escaper_utf8_truncate.sv
// json_string_escaper_utf8_truncate: streams string bytes out as a quoted,
// escaped JSON string literal with UTF-8-safe truncation.
// Depends on jse_pkg, jse_esc_unit and jse_hold_buf.
// An accepted item moves the block to S_RUN, where its first result is registered.
// Per item: accept, one result per cycle through the single escape unit while out_ready
// allows, then a finishing step before the next item is taken; k results, k is 0..26.
// Reset: control state cleared, limit register set to 300; hold buffer not cleared.
module json_string_escaper_utf8_truncate #(
    parameter int HOLD_DEPTH = jse_pkg::HOLD_DEPTH_DEF,
    parameter int INDEX_BITS = jse_pkg::INDEX_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  jse_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output jse_pkg::out_item_t              out_data,
    input  logic                            cfg_wr_en,
    input  logic [jse_pkg::MAX_BYTES_W-1:0] cfg_wr_data
);

    localparam int HOLD_BITS = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CNT_W     = $clog2(HOLD_DEPTH + 1);
    localparam int CMP_W     = (INDEX_BITS > jse_pkg::MAX_BYTES_W) ?
                               INDEX_BITS : jse_pkg::MAX_BYTES_W;
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HOLD_DEPTH);
    localparam logic [CNT_W-1:0] MASK_C  = CNT_W'(HOLD_DEPTH - 1);

    typedef enum logic {S_IDLE, S_RUN} state_t;

    state_t                          state_reg, state_next;
    logic                            opened_reg, opened_next;
    logic                            trunc_reg, trunc_next;
    logic [INDEX_BITS-1:0]           index_reg, index_next;
    logic [CNT_W-1:0]                hcount_reg, hcount_next;
    logic [jse_pkg::MAX_BYTES_W-1:0] max_reg;
    logic                            open_pend_reg, open_pend_next;
    logic                            close_pend_reg, close_pend_next;
    logic                            store_pend_reg, store_pend_next;
    logic [CNT_W-1:0]                flush_n_reg, flush_n_next;
    logic [CNT_W-1:0]                fidx_reg, fidx_next;
    logic [jse_pkg::ESC_STEP_W-1:0]  sub_reg, sub_next;
    logic [HOLD_BITS-1:0]            widx_reg, widx_next;
    logic [7:0]                      byte_reg, byte_next;
    logic                            out_valid_reg, out_valid_next;
    jse_pkg::out_item_t              out_data_reg, out_data_next;

    logic       acc;
    logic       cont;
    logic       slot_free;
    logic       do_flush;
    logic       wr_en;
    logic [7:0] rd_data;
    logic [7:0] esc_ch;
    logic       esc_last;
    logic [CNT_W-1:0] fidx_inc;
    logic [CNT_W-1:0] widx_wide;

    jse_hold_buf #(
        .HOLD_DEPTH (HOLD_DEPTH),
        .HOLD_BITS  (HOLD_BITS)
    ) u_hold (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_idx  (widx_reg),
        .wr_data (byte_reg),
        .rd_idx  (fidx_reg[HOLD_BITS-1:0]),
        .rd_data (rd_data)
    );

    jse_esc_unit u_esc (
        .c    (rd_data),
        .step (sub_reg),
        .ch   (esc_ch),
        .last (esc_last)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign acc       = in_valid && in_ready;
    assign cont      = (in_data.in_byte & jse_pkg::UTF8_CONT_MASK) == jse_pkg::UTF8_CONT_VAL;
    assign slot_free = !out_valid_reg || out_ready;
    assign fidx_inc  = fidx_reg + CNT_W'(1);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        opened_next     = opened_reg;
        trunc_next      = trunc_reg;
        index_next      = index_reg;
        hcount_next     = hcount_reg;
        open_pend_next  = open_pend_reg;
        close_pend_next = close_pend_reg;
        store_pend_next = store_pend_reg;
        flush_n_next    = flush_n_reg;
        fidx_next       = fidx_reg;
        sub_next        = sub_reg;
        widx_next       = widx_reg;
        byte_next       = byte_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        do_flush        = 1'b0;
        wr_en           = 1'b0;
        widx_wide       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    state_next      = S_RUN;
                    open_pend_next  = !opened_reg;
                    opened_next     = 1'b1;
                    close_pend_next = 1'b0;
                    store_pend_next = 1'b0;
                    fidx_next       = '0;
                    sub_next        = '0;
                    byte_next       = in_data.in_byte;
                    if (in_data.mode)
                    begin
                        do_flush        = !trunc_reg;
                        close_pend_next = 1'b1;
                        opened_next     = 1'b0;
                        trunc_next      = 1'b0;
                        index_next      = '0;
                        hcount_next     = '0;
                    end
                    else if (!trunc_reg)
                    begin
                        if (CMP_W'(index_reg) >= CMP_W'(max_reg))
                        begin
                            trunc_next  = 1'b1;
                            do_flush    = !cont;
                            hcount_next = '0;
                        end
                        else
                        begin
                            do_flush        = !cont || (hcount_reg >= DEPTH_C);
                            store_pend_next = 1'b1;
                            widx_wide       = (do_flush ? '0 : hcount_reg) & MASK_C;
                            widx_next       = widx_wide[HOLD_BITS-1:0];
                            hcount_next     = do_flush ? CNT_W'(1) : hcount_reg + CNT_W'(1);
                            if (index_reg != INDEX_MAX)
                            begin
                                index_next = index_reg + INDEX_BITS'(1);
                            end
                        end
                    end
                    flush_n_next = do_flush ? hcount_reg : '0;
                end
            end
            S_RUN:
            begin
                if (open_pend_reg)
                begin
                    if (slot_free)
                    begin
                        open_pend_next = 1'b0;
                        out_valid_next = 1'b1;
                        out_data_next  = '{out_byte: jse_pkg::CH_QUOTE,
                                           run_last: (flush_n_reg == '0) && !close_pend_reg,
                                           string_done: 1'b0};
                    end
                end
                else if (fidx_reg != flush_n_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{out_byte: esc_ch,
                                           run_last: esc_last && (fidx_inc == flush_n_reg)
                                                     && !close_pend_reg,
                                           string_done: 1'b0};
                        if (esc_last)
                        begin
                            fidx_next = fidx_inc;
                            sub_next  = '0;
                        end
                        else
                        begin
                            sub_next = sub_reg + jse_pkg::ESC_STEP_W'(1);
                        end
                    end
                end
                else if (close_pend_reg)
                begin
                    if (slot_free)
                    begin
                        close_pend_next = 1'b0;
                        out_valid_next  = 1'b1;
                        out_data_next   = '{out_byte: jse_pkg::CH_QUOTE,
                                            run_last: 1'b1,
                                            string_done: 1'b1};
                    end
                end
                else
                begin
                    // new byte goes in only after the old ones are flushed
                    wr_en           = store_pend_reg;
                    store_pend_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            opened_reg     <= 1'b0;
            trunc_reg      <= 1'b0;
            index_reg      <= '0;
            hcount_reg     <= '0;
            max_reg        <= jse_pkg::MAX_BYTES_RST;
            open_pend_reg  <= 1'b0;
            close_pend_reg <= 1'b0;
            store_pend_reg <= 1'b0;
            flush_n_reg    <= '0;
            fidx_reg       <= '0;
            sub_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            opened_reg     <= opened_next;
            trunc_reg      <= trunc_next;
            index_reg      <= index_next;
            hcount_reg     <= hcount_next;
            open_pend_reg  <= open_pend_next;
            close_pend_reg <= close_pend_next;
            store_pend_reg <= store_pend_next;
            flush_n_reg    <= flush_n_next;
            fidx_reg       <= fidx_next;
            sub_reg        <= sub_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        widx_reg     <= widx_next;
        byte_reg     <= byte_next;
        out_data_reg <= out_data_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> !in_ready)
        else $error("block ready straight after a transaction");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.string_done) |-> out_data.run_last)
        else $error("closing quote not marked last");

    a_done_is_quote: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.string_done) |-> (out_data.out_byte == jse_pkg::CH_QUOTE))
        else $error("closing byte is not a quote");

    a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (hcount_reg <= DEPTH_C) && (flush_n_reg <= DEPTH_C))
        else $error("hold count beyond buffer depth");

endmodule

### dv/json_string_escaper_utf8_truncate_tb.sv
// Self-checking testbench for json_string_escaper_utf8_truncate: random and directed strings
// are checked byte for byte against an in-bench escaping and truncation predictor.
// Depends on jse_pkg and the json_string_escaper_utf8_truncate RTL.
`timescale 1ns / 1ps

module json_string_escaper_utf8_truncate_tb;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_END  = 1'b1;
    localparam int HOLD_DEPTH = jse_pkg::HOLD_DEPTH_DEF;
    localparam int INDEX_BITS = jse_pkg::INDEX_BITS_DEF;
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
    localparam logic [7:0] CH_A_LOWER = 8'h61;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    jse_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    jse_pkg::out_item_t out_data;
    logic cfg_wr_en = 1'b0;
    logic [jse_pkg::MAX_BYTES_W-1:0] cfg_wr_data = '0;

    // predictor state
    logic [jse_pkg::MAX_BYTES_W-1:0] limit_q = jse_pkg::MAX_BYTES_RST;
    logic str_open = 1'b0;
    logic str_cut = 1'b0;
    logic [INDEX_BITS-1:0] kept_count = '0;
    logic [7:0] held_buf [HOLD_DEPTH];
    int held_n = 0;

    logic [7:0] burst_byte [$];
    logic burst_done [$];
    jse_pkg::out_item_t json_expected [$];
    jse_pkg::in_item_t pending_items [$];
    jse_pkg::out_item_t exp_item;

    logic idle_on = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int fail_count = 0;
    int n_accepted = 0;
    int n_strings = 0;
    int n_results = 0;
    int n_cuts = 0;

    json_string_escaper_utf8_truncate i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(10_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void emit_char(input logic [7:0] b, input logic done);
        burst_byte.push_back(b);
        burst_done.push_back(done);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10)
        begin
            d = jse_pkg::CH_ZERO + {4'd0, nib};
        end
        else
        begin
            d = CH_A_LOWER + {4'd0, nib} - 8'd10;
        end
        return d;
    endfunction

    function automatic void escape_char(input logic [7:0] c);
        case (c)
            jse_pkg::CH_QUOTE:
            begin
                emit_char(jse_pkg::CH_BSLASH, 1'b0);
                emit_char(jse_pkg::CH_QUOTE, 1'b0);
            end
            jse_pkg::CH_BSLASH:
            begin
                emit_char(jse_pkg::CH_BSLASH, 1'b0);
                emit_char(jse_pkg::CH_BSLASH, 1'b0);
            end
            jse_pkg::CH_LF:
            begin
                emit_char(jse_pkg::CH_BSLASH, 1'b0);
                emit_char(jse_pkg::CH_N, 1'b0);
            end
            jse_pkg::CH_CR:
            begin
                emit_char(jse_pkg::CH_BSLASH, 1'b0);
                emit_char(jse_pkg::CH_R, 1'b0);
            end
            jse_pkg::CH_TAB:
            begin
                emit_char(jse_pkg::CH_BSLASH, 1'b0);
                emit_char(jse_pkg::CH_T, 1'b0);
            end
            default:
            begin
                if (c < jse_pkg::CTRL_LIMIT)
                begin
                    emit_char(jse_pkg::CH_BSLASH, 1'b0);
                    emit_char(jse_pkg::CH_U, 1'b0);
                    emit_char(jse_pkg::CH_ZERO, 1'b0);
                    emit_char(jse_pkg::CH_ZERO, 1'b0);
                    emit_char(hex_char(c[7:4]), 1'b0);
                    emit_char(hex_char(c[3:0]), 1'b0);
                end
                else
                begin
                    emit_char(c, 1'b0);
                end
            end
        endcase
    endfunction

    function automatic void flush_held_bytes();
        for (int i = 0; i < held_n; i++)
        begin
            escape_char(held_buf[i]);
        end
        held_n = 0;
    endfunction

    function automatic void predict_json(input jse_pkg::in_item_t it);
        logic cont;
        int n;
        cont = (it.in_byte & jse_pkg::UTF8_CONT_MASK) == jse_pkg::UTF8_CONT_VAL;
        burst_byte.delete();
        burst_done.delete();
        if (!str_open)
        begin
            emit_char(jse_pkg::CH_QUOTE, 1'b0);
            str_open = 1'b1;
        end
        if (it.mode == MODE_END)
        begin
            if (!str_cut)
            begin
                flush_held_bytes();
            end
            emit_char(jse_pkg::CH_QUOTE, 1'b1);
            str_open = 1'b0;
            str_cut = 1'b0;
            kept_count = '0;
            held_n = 0;
            n_strings++;
        end
        else if (!str_cut)
        begin
            if (kept_count >= {1'b0, limit_q})
            begin
                str_cut = 1'b1;
                n_cuts++;
                if (cont)
                begin
                    held_n = 0;
                end
                else
                begin
                    flush_held_bytes();
                end
            end
            else
            begin
                if (!cont || held_n >= HOLD_DEPTH)
                begin
                    flush_held_bytes();
                end
                held_buf[held_n] = it.in_byte;
                held_n++;
                if (kept_count < INDEX_MAX)
                begin
                    kept_count++;
                end
            end
        end
        n = burst_byte.size();
        for (int i = 0; i < n; i++)
        begin
            json_expected.push_back(jse_pkg::out_item_t'{out_byte: burst_byte[i],
                                                         run_last: (i == n - 1),
                                                         string_done: burst_done[i]});
        end
    endfunction

    // ---------------------------------------------------------------- driver and monitor

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 2);
        end
        else if (r < 97)
        begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(10, 30);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_json(in_data);
                n_accepted++;
            end
            if (in_valid && !in_ready)
            begin
                // holding the current transaction
            end
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_items.size() > 0)
            begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
                send_gap = idle_on ? pick_gap() : 0;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    task automatic report(input string what, input jse_pkg::out_item_t want,
                          input jse_pkg::out_item_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%0t %s: exp byte %02h last %0b done %0b, got byte %02h last %0b done %0b",
                     $realtime, what, want.out_byte, want.run_last, want.string_done,
                     got.out_byte, got.run_last, got.string_done);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (json_expected.size() == 0)
                begin
                    report("unexpected output", '0, out_data);
                end
                else
                begin
                    exp_item = json_expected.pop_front();
                    if (out_data.out_byte !== exp_item.out_byte
                        || out_data.run_last !== exp_item.run_last
                        || out_data.string_done !== exp_item.string_done)
                    begin
                        report("mismatch", exp_item, out_data);
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic void push_byte(input logic [7:0] b);
        pending_items.push_back(jse_pkg::in_item_t'{mode: MODE_BYTE, in_byte: b});
    endfunction

    function automatic void push_end();
        pending_items.push_back(jse_pkg::in_item_t'{mode: MODE_END,
                                                    in_byte: 8'($urandom_range(0, 255))});
    endfunction

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || json_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [jse_pkg::MAX_BYTES_W-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        limit_q = v;
    endtask

    function automatic logic [7:0] rand_cont();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // one symbol of a string; returns the number of bytes queued
    function automatic int push_symbol();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            push_byte(8'($urandom_range(8'h20, 8'h7E)));
            return 1;
        end
        else if (r < 50)
        begin
            case ($urandom_range(0, 4))
                0: push_byte(jse_pkg::CH_QUOTE);
                1: push_byte(jse_pkg::CH_BSLASH);
                2: push_byte(jse_pkg::CH_LF);
                3: push_byte(jse_pkg::CH_CR);
                default: push_byte(jse_pkg::CH_TAB);
            endcase
            return 1;
        end
        else if (r < 58)
        begin
            push_byte(8'($urandom_range(0, 31)));
            return 1;
        end
        else if (r < 83)
        begin
            len = $urandom_range(2, 4);
            case (len)
                2: push_byte(8'($urandom_range(8'hC2, 8'hDF)));
                3: push_byte(8'($urandom_range(8'hE0, 8'hEF)));
                default: push_byte(8'($urandom_range(8'hF0, 8'hF7)));
            endcase
            for (int k = 1; k < len; k++)
            begin
                push_byte(rand_cont());
            end
            return len;
        end
        else if (r < 93)
        begin
            len = $urandom_range(1, 7);
            for (int k = 0; k < len; k++)
            begin
                push_byte(rand_cont());
            end
            return len;
        end
        push_byte(8'($urandom_range(0, 255)));
        return 1;
    endfunction

    task automatic run_strings(input int n_items, input int max_len);
        int sent;
        int target;
        int got;
        sent = 0;
        while (sent < n_items)
        begin
            target = ($urandom_range(0, 9) == 0) ? $urandom_range(0, max_len)
                                                  : $urandom_range(0, 10);
            got = 0;
            while (got < target)
            begin
                got += push_symbol();
            end
            push_end();
            sent += got + 1;
        end
    endtask

    task automatic run_phase(input logic [jse_pkg::MAX_BYTES_W-1:0] lim, input int n_items,
                             input logic idle);
        wait_drained();
        write_limit(lim);
        idle_on = idle;
        run_strings(n_items, 40);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset limit of 300
        idle_on = 1'b1;
        push_end();
        push_byte(jse_pkg::CH_QUOTE);
        push_byte(jse_pkg::CH_BSLASH);
        push_byte(jse_pkg::CH_LF);
        push_byte(jse_pkg::CH_CR);
        push_byte(jse_pkg::CH_TAB);
        push_byte(8'h00);
        push_byte(8'h1F);
        push_byte(8'h20);
        push_byte(8'h7F);
        push_byte(8'hFF);
        push_end();
        push_byte(8'hE2);
        push_byte(8'h82);
        push_byte(8'hAC);
        push_end();
        // overlong continuation run spills the hold buffer early
        push_byte(8'hC3);
        push_byte(8'h80);
        push_byte(8'hBF);
        push_byte(8'hA9);
        push_byte(8'h81);
        push_byte(8'h9C);
        push_end();

        // limit changed part-way through a string
        push_byte(8'h41);
        push_byte(8'hC3);
        push_byte(8'hA9);
        push_byte(8'hC3);
        wait_drained();
        write_limit(10'd2);
        push_byte(8'hA9);
        push_byte(8'h78);
        push_end();

        run_phase(10'd1023, 20, 1'b1);
        run_phase(10'd0, 20, 1'b1);
        run_phase(10'd1, 20, 1'b0);
        run_phase(10'd3, 20, 1'b1);
        run_phase(10'd5, 20, 1'b1);
        run_phase(10'd7, 20, 1'b0);
        run_phase(10'd16, 20, 1'b1);
        run_phase(10'($urandom_range(0, 1023)), 20, 1'b1);
        run_phase(jse_pkg::MAX_BYTES_RST, 25, 1'b1);
        wait_drained();

        $display("Covered %0d strings from %0d input transactions, %0d output bytes,",
                 n_strings, n_accepted, n_results);
        $display("%0d truncations over limits 0 to 1023, with and without back-pressure.",
                 n_cuts);
        if (fail_count == 0 && json_expected.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
